// File: rtl/frx_pkg.sv
package frx_pkg;

	localparam int unsigned FRX_REGION_BYTES = 131072;

	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
	localparam logic [15:0] CHUNK_NONE = 16'hFFFF;

	// register select, taken from paddr[2]
	localparam logic REG_BASE   = 1'b0;
	localparam logic REG_MARKER = 1'b1;

	typedef enum logic [2:0] {
		CMD_START  = 3'd0,
		CMD_HEADER = 3'd1,
		CMD_BYTE   = 3'd2,
		CMD_END    = 3'd3,
		CMD_ABORT  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RECV = 2'd1,
		PH_DONE = 2'd2,
		PH_ERR  = 2'd3
	} phase_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] image_size;
		logic [31:0] expected_check;
		logic [15:0] chunk_number;
		logic [7:0]  chunk_length;
		logic [7:0]  data_byte;
	} item_t;

	typedef struct packed {
		logic        accepted;
		phase_t      phase;
		logic        erase_request;
		logic        write_valid;
		logic        write_is_word;
		logic [31:0] write_address;
		logic [31:0] write_value;
		logic        reset_request;
	} result_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		end
		return x;
	endfunction

endpackage

// File: rtl/firmware_update_receiver.sv
// Firmware update receiver. Items come in on the s_ side (command in s_tuser), one result per
// item leaves on the m_ side. An item is taken every cycle while results drain; an item is
// held in the input register, then its result in the result register that drives m_tvalid,
// and a stalled m_ side keeps the item waiting in the input register. The whole state update,
// including one byte of CRC-32, is combinational between the two registers. Program
// region_base and pending_marker over APB before sending start.
module firmware_update_receiver
	import frx_pkg::*;
#(
	parameter int unsigned REGION_BYTES = FRX_REGION_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// image_size[31:0], expected_check[63:32], chunk_number[79:64],
	// chunk_length[87:80], data_byte[95:88]
	input  logic [95:0] s_tdata,
	// command[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// accepted[0], phase[2:1], erase_request[3], write_valid[4],
	// write_address[36:5], write_value[68:37], reset_request[69], zero[71:70]
	output logic [71:0] m_tdata,
	// write_is_word[0]
	output logic [0:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] region_base_q;
	logic [31:0] pending_marker_q;
	item_t       in_item;
	item_t       item_s1;
	logic        valid_s1;
	logic        out_free;
	logic        step;
	result_t     core_result;
	result_t     out_result;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MARKER) ? pending_marker_q : region_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q    <= '0;
			pending_marker_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_BASE:   region_base_q    <= pwdata;
				REG_MARKER: pending_marker_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	assign in_item.command        = cmd_t'(s_tuser);
	assign in_item.image_size     = s_tdata[31:0];
	assign in_item.expected_check = s_tdata[63:32];
	assign in_item.chunk_number   = s_tdata[79:64];
	assign in_item.chunk_length   = s_tdata[87:80];
	assign in_item.data_byte      = s_tdata[95:88];

	assign step = valid_s1 && out_free;

	frx_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_item      (in_item),
		.step         (step),
		.item_valid_s1(valid_s1),
		.item_s1      (item_s1)
	);

	frx_core #(
		.REGION_BYTES(REGION_BYTES)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.item          (item_s1),
		.region_base   (region_base_q),
		.pending_marker(pending_marker_q),
		.result        (core_result)
	);

	frx_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_result(core_result),
		.out_free   (out_free),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	assign m_tdata = {2'b00, out_result.reset_request, out_result.write_value,
		out_result.write_address, out_result.write_valid, out_result.erase_request,
		out_result.phase, out_result.accepted};
	assign m_tuser = out_result.write_is_word;

endmodule

// File: rtl/frx_in_stage.sv
module frx_in_stage
	import frx_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  step,
	output logic  item_valid_s1,
	output item_t item_s1
);

	logic valid_s1;

	assign in_ready      = !valid_s1 || step;
	assign item_valid_s1 = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: rtl/frx_core.sv
module frx_core
	import frx_pkg::*;
#(
	parameter int unsigned REGION_BYTES = FRX_REGION_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  item_t       item,
	input  logic [31:0] region_base,
	input  logic [31:0] pending_marker,
	output result_t     result
);

	localparam int unsigned CNT_W = $clog2(REGION_BYTES + 1);
	localparam int unsigned SUM_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
	localparam logic [31:0] REGION_SIZE = 32'(REGION_BYTES);
	localparam logic [SUM_W-1:0] REGION_LIM = SUM_W'(REGION_BYTES);
	localparam logic [31:0] MARKER_OFS = 32'(REGION_BYTES - 4);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] bytes_q, bytes_d;
	logic [15:0]      last_q, last_d;
	logic [31:0]      crc_q, crc_d;
	logic [31:0]      exp_q, exp_d;
	logic [7:0]       left_q, left_d;
	logic             skip_q, skip_d;
	logic [SUM_W-1:0] sum;

	assign sum = SUM_W'(bytes_q) + SUM_W'(item.chunk_length);

	always_comb begin
		phase_d = phase_q;
		bytes_d = bytes_q;
		last_d  = last_q;
		crc_d   = crc_q;
		exp_d   = exp_q;
		left_d  = left_q;
		skip_d  = skip_q;
		result  = '0;
		case (item.command)
			CMD_START: begin
				exp_d  = item.expected_check;
				bytes_d = '0;
				last_d = CHUNK_NONE;
				crc_d  = CRC_INIT;
				left_d = '0;
				skip_d = 1'b0;
				if (item.image_size > REGION_SIZE) begin
					phase_d = PH_ERR;
				end else begin
					phase_d = PH_RECV;
					result.erase_request = 1'b1;
					result.accepted = 1'b1;
				end
			end
			CMD_HEADER: begin
				if (phase_q == PH_RECV) begin
					if (item.chunk_number == last_q) begin
						skip_d = 1'b1;
						left_d = item.chunk_length;
						result.accepted = 1'b1;
					end else if (sum > REGION_LIM) begin
						phase_d = PH_ERR;
						left_d  = '0;
						skip_d  = 1'b0;
					end else begin
						skip_d = 1'b0;
						left_d = item.chunk_length;
						last_d = item.chunk_number;
						result.accepted = 1'b1;
					end
				end
			end
			CMD_BYTE: begin
				if (phase_q == PH_RECV && left_q != '0) begin
					left_d = left_q - 8'd1;
					result.accepted = 1'b1;
					if (!skip_q) begin
						result.write_valid   = 1'b1;
						result.write_address = region_base + 32'(bytes_q);
						result.write_value   = {24'd0, item.data_byte};
						crc_d   = crc_byte(crc_q, item.data_byte);
						bytes_d = bytes_q + CNT_W'(1);
					end
				end
			end
			CMD_END: begin
				if (phase_q == PH_RECV) begin
					left_d = '0;
					skip_d = 1'b0;
					if (~crc_q != exp_q) begin
						phase_d = PH_ERR;
					end else begin
						phase_d = PH_DONE;
						result.write_valid   = 1'b1;
						result.write_is_word = 1'b1;
						result.write_address = region_base + MARKER_OFS;
						result.write_value   = pending_marker;
						result.reset_request = 1'b1;
						result.accepted      = 1'b1;
					end
				end
			end
			CMD_ABORT: begin
				phase_d = PH_IDLE;
				bytes_d = '0;
				left_d  = '0;
				skip_d  = 1'b0;
				result.accepted = 1'b1;
			end
			default: begin
			end
		endcase
		result.phase = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bytes_q <= '0;
			last_q  <= '0;
			crc_q   <= CRC_INIT;
			exp_q   <= '0;
			left_q  <= '0;
			skip_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			bytes_q <= bytes_d;
			last_q  <= last_d;
			crc_q   <= crc_d;
			exp_q   <= exp_d;
			left_q  <= left_d;
			skip_q  <= skip_d;
		end
	end

endmodule

// File: rtl/frx_out_stage.sv
module frx_out_stage
	import frx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load_valid,
	input  result_t load_result,
	output logic    out_free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_result
);

	logic    valid_q;
	result_t result_q;

	assign out_free   = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load_valid) begin
			result_q <= load_result;
		end
	end

endmodule

// File: rtl/frx_checker.sv
module frx_checker
	import frx_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [0:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[68:5] == 64'd0 && m_tuser == 1'b0)
		else $error("write fields set without write_valid");

	a_reset_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[69] |->
			m_tdata[0] && m_tdata[2:1] == PH_DONE && m_tdata[4] && m_tuser[0])
		else $error("reset request without successful end");

	a_erase_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[0] && m_tdata[2:1] == PH_RECV && !m_tdata[4])
		else $error("erase request without accepted start");

	a_word_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[69])
		else $error("marker write without reset request");

endmodule

bind firmware_update_receiver frx_checker u_frx_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// File: dv/firmware_update_receiver_test.sv
module firmware_update_receiver_test;
	import frx_pkg::*;

	localparam logic [31:0] IMAGE_REGION_BYTES = FRX_REGION_BYTES;
	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] image_size;
		logic [31:0] expected_check;
		logic [15:0] chunk_number;
		logic [7:0]  chunk_length;
		logic [7:0]  data_byte;
	} fw_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	fw_item_t pending_items[$];
	result_t  results_due[$];
	fw_item_t next_item;
	result_t  due_now;

	int unsigned send_idle_pct = 34;
	int unsigned recv_idle_pct = 79;
	int          rx_hold = 0;
	int unsigned mismatches = 0;

	// receiver state as the block should hold it
	logic [31:0] cfg_base = '0;
	logic [31:0] cfg_marker = '0;
	phase_t      rx_phase = PH_IDLE;
	logic [24:0] rx_stored = '0;
	logic [15:0] rx_last_seq = '0;
	logic [31:0] rx_crc = CRC_INIT;
	logic [31:0] rx_want_crc = '0;
	logic [7:0]  rx_left = '0;
	logic        rx_dup = 1'b0;

	firmware_update_receiver u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] crc32_fold(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		logic        fb;
		int          i;
		c = crc;
		for (i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic result_t advance_receiver(logic [2:0] op, logic [31:0] size,
			logic [31:0] chk, logic [15:0] num, logic [7:0] len, logic [7:0] dat);
		result_t r;
		r = '0;
		case (op)
		CMD_START: begin
			rx_want_crc = chk;
			rx_stored = '0;
			rx_last_seq = CHUNK_NONE;
			rx_crc = CRC_INIT;
			rx_left = '0;
			rx_dup = 1'b0;
			if (size > IMAGE_REGION_BYTES) begin
				rx_phase = PH_ERR;
			end else begin
				rx_phase = PH_RECV;
				r.erase_request = 1'b1;
				r.accepted = 1'b1;
			end
		end
		CMD_HEADER: if (rx_phase == PH_RECV) begin
			if (num == rx_last_seq) begin
				rx_dup = 1'b1;
				rx_left = len;
				r.accepted = 1'b1;
			end else if ({7'd0, rx_stored} + {24'd0, len} > IMAGE_REGION_BYTES) begin
				rx_phase = PH_ERR;
				rx_left = '0;
				rx_dup = 1'b0;
			end else begin
				rx_dup = 1'b0;
				rx_left = len;
				rx_last_seq = num;
				r.accepted = 1'b1;
			end
		end
		CMD_BYTE: if (rx_phase == PH_RECV && rx_left != 0) begin
			rx_left = rx_left - 8'd1;
			r.accepted = 1'b1;
			if (!rx_dup) begin
				r.write_valid = 1'b1;
				r.write_address = cfg_base + {7'd0, rx_stored};
				r.write_value = {24'd0, dat};
				rx_crc = crc32_fold(rx_crc, dat);
				rx_stored = rx_stored + 25'd1;
			end
		end
		CMD_END: if (rx_phase == PH_RECV) begin
			rx_left = '0;
			rx_dup = 1'b0;
			if (~rx_crc != rx_want_crc) begin
				rx_phase = PH_ERR;
			end else begin
				rx_phase = PH_DONE;
				r.write_valid = 1'b1;
				r.write_is_word = 1'b1;
				r.write_address = cfg_base + IMAGE_REGION_BYTES - 32'd4;
				r.write_value = cfg_marker;
				r.reset_request = 1'b1;
				r.accepted = 1'b1;
			end
		end
		CMD_ABORT: begin
			rx_phase = PH_IDLE;
			rx_stored = '0;
			rx_left = '0;
			rx_dup = 1'b0;
			r.accepted = 1'b1;
		end
		default: ;
		endcase
		r.phase = rx_phase;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic fw_item_t start_of(logic [31:0] size, logic [31:0] chk);
		return '{op: CMD_START, image_size: size, expected_check: chk,
			chunk_number: 16'($urandom), chunk_length: 8'($urandom), data_byte: 8'($urandom)};
	endfunction

	function automatic fw_item_t header_of(logic [15:0] num, logic [7:0] len);
		return '{op: CMD_HEADER, image_size: $urandom, expected_check: $urandom,
			chunk_number: num, chunk_length: len, data_byte: 8'($urandom)};
	endfunction

	function automatic fw_item_t byte_of(logic [7:0] b);
		return '{op: CMD_BYTE, image_size: $urandom, expected_check: $urandom,
			chunk_number: 16'($urandom), chunk_length: 8'($urandom), data_byte: b};
	endfunction

	function automatic fw_item_t bare(logic [2:0] op);
		return '{op: op, image_size: $urandom, expected_check: $urandom,
			chunk_number: 16'($urandom), chunk_length: 8'($urandom), data_byte: 8'($urandom)};
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				results_due.push_back(advance_receiver(s_tuser, s_tdata[31:0], s_tdata[63:32],
					s_tdata[79:64], s_tdata[87:80], s_tdata[95:88]));
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {next_item.data_byte, next_item.chunk_length, next_item.chunk_number,
						next_item.expected_check, next_item.image_size};
					s_tuser <= next_item.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$error("result transfer with nothing outstanding: tdata %h", m_tdata);
					mismatches++;
				end else begin
					due_now = results_due.pop_front();
					check_field("accepted", 32'(due_now.accepted), 32'(m_tdata[0]));
					check_field("phase", 32'(due_now.phase), 32'(m_tdata[2:1]));
					check_field("erase_request", 32'(due_now.erase_request), 32'(m_tdata[3]));
					check_field("write_valid", 32'(due_now.write_valid), 32'(m_tdata[4]));
					check_field("write_is_word", 32'(due_now.write_is_word), 32'(m_tuser[0]));
					check_field("write_address", due_now.write_address, m_tdata[36:5]);
					check_field("write_value", due_now.write_value, m_tdata[68:37]);
					check_field("reset_request", 32'(due_now.reset_request), 32'(m_tdata[69]));
				end
			end
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold <= rx_hold - 1;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic program_register(logic sel, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (sel == REG_BASE)
			cfg_base = value;
		else
			cfg_marker = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("prdata", value, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || results_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic queue_directed();
		logic [31:0] two_byte_crc;
		two_byte_crc = ~crc32_fold(crc32_fold(CRC_INIT, 8'h00), 8'hFF);
		pending_items.push_back(header_of(16'h0001, 8'd4));
		pending_items.push_back(byte_of(8'hFF));
		pending_items.push_back(bare(CMD_END));
		pending_items.push_back(bare(CMD_UNUSED_FIRST));
		pending_items.push_back(bare(CMD_UNUSED_LAST));
		pending_items.push_back(start_of(IMAGE_REGION_BYTES + 32'd1, $urandom));
		pending_items.push_back(header_of(16'h0002, 8'd1));
		pending_items.push_back(start_of(32'hFFFF_FFFF, $urandom));
		pending_items.push_back(start_of(IMAGE_REGION_BYTES, two_byte_crc));
		pending_items.push_back(byte_of(8'h00));
		// first header repeats the preset chunk number: its bytes are dropped
		pending_items.push_back(header_of(CHUNK_NONE, 8'd2));
		pending_items.push_back(byte_of(8'h5A));
		pending_items.push_back(byte_of(8'hC3));
		pending_items.push_back(header_of(16'h0000, 8'd3));
		pending_items.push_back(byte_of(8'h00));
		// cuts the previous chunk short, length above the usual maximum
		pending_items.push_back(header_of(16'h0001, 8'd255));
		pending_items.push_back(byte_of(8'hFF));
		pending_items.push_back(bare(CMD_END));
		pending_items.push_back(byte_of(8'h11));
		pending_items.push_back(bare(CMD_ABORT));
		pending_items.push_back(start_of(32'd0, 32'd0));
		pending_items.push_back(bare(CMD_END));
		pending_items.push_back(start_of(32'd5, 32'hDEAD_BEEF));
		pending_items.push_back(header_of(16'h0007, 8'd0));
		pending_items.push_back(bare(CMD_END));
	endtask

	task automatic queue_random(int unsigned n);
		fw_item_t    body[$];
		int unsigned added, chunks, len, sent, dup_len;
		logic [31:0] crc, check, size;
		logic [15:0] seq;
		logic [7:0]  b;
		added = 0;
		while (added < n) begin
			body.delete();
			crc = CRC_INIT;
			seq = 16'($urandom);
			chunks = $urandom_range(1, 4);
			repeat (chunks) begin
				seq = ($urandom_range(15) == 0) ? 16'($urandom) : seq + 16'd1;
				len = ($urandom_range(39) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 10);
				sent = ($urandom_range(11) == 0) ? $urandom_range(0, len) : len;
				body.push_back(header_of(seq, 8'(len)));
				repeat (sent) begin
					b = 8'($urandom);
					crc = crc32_fold(crc, b);
					body.push_back(byte_of(b));
				end
				if ($urandom_range(5) == 0) begin
					// resent chunk, skipped
					dup_len = $urandom_range(0, 6);
					body.push_back(header_of(seq, 8'(dup_len)));
					repeat (dup_len) body.push_back(byte_of(8'($urandom)));
					sent = len;
				end
				if (sent == len && $urandom_range(9) == 0)
					body.push_back(byte_of(8'($urandom)));
				if ($urandom_range(11) == 0)
					body.push_back(bare(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST))));
			end
			check = ~crc;
			if ($urandom_range(9) == 0)
				check = check ^ (32'd1 << $urandom_range(31));
			if ($urandom_range(24) == 0)
				size = $urandom_range(32'hFFFF_FFFF, IMAGE_REGION_BYTES + 32'd1);
			else
				size = $urandom_range(IMAGE_REGION_BYTES, 0);
			pending_items.push_back(start_of(size, check));
			foreach (body[i])
				pending_items.push_back(body[i]);
			case ($urandom_range(11))
			0: pending_items.push_back(bare(CMD_ABORT));
			1: ;
			default: pending_items.push_back(bare(CMD_END));
			endcase
			if ($urandom_range(7) == 0)
				pending_items.push_back(byte_of(8'($urandom)));
			added += body.size() + 3;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		program_register(REG_BASE, 32'hFFFF_FFF0);
		program_register(REG_MARKER, $urandom);
		@(negedge clk);
		queue_directed();
		queue_random(200);
		wait_drained();
		program_register(REG_BASE, 32'h0000_0000);
		program_register(REG_MARKER, 32'hFFFF_FFFF);
		@(negedge clk);
		queue_random(150);
		rx_hold = 400;
		wait_drained();
		send_idle_pct = 79;
		recv_idle_pct = 34;
		program_register(REG_BASE, $urandom);
		program_register(REG_MARKER, 32'h0000_0000);
		@(negedge clk);
		queue_random(400);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_register(REG_BASE, 32'hFFFF_FFFF);
		program_register(REG_MARKER, $urandom);
		@(negedge clk);
		queue_random(350);
		wait_drained();
		if (mismatches == 0)
			$display("firmware_update_receiver verification clean");
		else
			$display("firmware_update_receiver verification failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("firmware_update_receiver verification failed");
		$finish;
	end

endmodule
